/* design/bpm_pkg.sv */
// bpm_pkg: types and constants shared by the bipartite matching block.
// No dependencies; imported by every module of the block.
package bpm_pkg;

    localparam int COL_W    = 5;
    localparam int NUM_COLS = 32;
    localparam int ROW_W    = 32;
    localparam int CFG_W    = 6;
    localparam int N_W      = 7;
    localparam int SIZE_W   = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_FETCH,
        ST_SCAN,
        ST_PROBE,
        ST_UNWIND,
        ST_DONE
    } search_state_t;

    // column partner store access from the search sequencer
    typedef struct packed {
        logic             clear;
        logic             re;
        logic [COL_W-1:0] raddr;
        logic             we;
        logic [COL_W-1:0] waddr;
    } cp_ctrl_t;

endpackage

/* design/bpm_row_store.sv */
// bpm_row_store: synchronous memory holding the loaded matrix rows.
// Depends on bpm_pkg; one write port, one registered read port.
module bpm_row_store
    import bpm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/bpm_col_partner.sv */
// bpm_col_partner: per-column partner row memory with flop valid bits.
// Depends on bpm_pkg; a single clear drops every valid bit.
module bpm_col_partner
    import bpm_pkg::*;
#(
    parameter int RW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cp_ctrl_t      ctrl,
    input  logic [RW-1:0] wdata,
    output logic          rvalid,
    output logic [RW-1:0] rdata
);

    logic [RW-1:0]       mem [NUM_COLS];
    logic [NUM_COLS-1:0] valid_reg;
    logic                rvalid_reg;
    logic [RW-1:0]       rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                valid_reg <= '0;
            end else if (ctrl.we) begin
                valid_reg[ctrl.waddr] <= 1'b1;
            end
            if (ctrl.re) begin
                rvalid_reg <= valid_reg[ctrl.raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[ctrl.waddr] <= wdata;
        end
        if (ctrl.re) begin
            rdata_reg <= mem[ctrl.raddr];
        end
    end

    assign rvalid = rvalid_reg;
    assign rdata  = rdata_reg;

endmodule

/* design/bpm_search.sv */
// bpm_search: augmenting-path sequencer over the row store and partner memory.
// Depends on bpm_pkg; drives the read port of bpm_row_store and all of bpm_col_partner.
module bpm_search
    import bpm_pkg::*;
#(
    parameter int MAX_SIZE = 32,
    parameter int RW       = 5,
    parameter int CNTW     = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CNTW-1:0]   rows,
    input  logic [ROW_W-1:0]  cmask,
    input  logic              out_free,
    output logic              done,
    output logic [SIZE_W-1:0] size,
    output logic              rs_re,
    output logic [RW-1:0]     rs_addr,
    input  logic [ROW_W-1:0]  rs_data,
    output cp_ctrl_t          cp_ctrl,
    output logic [RW-1:0]     cp_wdata,
    input  logic              cp_rvalid,
    input  logic [RW-1:0]     cp_rdata
);

    search_state_t state_reg, state_next;

    logic [CNTW-1:0]   root_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [RW-1:0]     depth_reg;
    logic [RW-1:0]     top_row_reg;
    logic [ROW_W-1:0]  top_bits_reg;
    logic [ROW_W-1:0]  visited_reg;
    logic [COL_W-1:0]  col_reg;
    logic [RW-1:0]     stack_row [MAX_SIZE];
    logic [COL_W-1:0]  stack_col [MAX_SIZE];

    logic [ROW_W-1:0] cand;
    logic [COL_W-1:0] low_col;
    logic [RW-1:0]    depth_dn;
    logic             at_root;
    logic             roots_done;

    function automatic logic [COL_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    assign cand       = top_bits_reg & cmask & ~visited_reg;
    assign low_col    = lowest_set(cand);
    assign depth_dn   = depth_reg - RW'(1);
    assign at_root    = (depth_reg == '0);
    assign roots_done = (root_reg == rows);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_ROOT;
            ST_ROOT:   state_next = roots_done ? ST_DONE : ST_FETCH;
            ST_FETCH:  state_next = ST_SCAN;
            ST_SCAN: begin
                if (cand != '0) begin
                    state_next = ST_PROBE;
                end else begin
                    state_next = at_root ? ST_ROOT : ST_FETCH;
                end
            end
            ST_PROBE: begin
                if (cp_rvalid) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = at_root ? ST_ROOT : ST_UNWIND;
                end
            end
            ST_UNWIND: if (at_root) state_next = ST_ROOT;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rs_re    = 1'b0;
        rs_addr  = root_reg[RW-1:0];
        cp_ctrl  = '0;
        cp_wdata = top_row_reg;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  cp_ctrl.clear = start;
            ST_ROOT:  rs_re = !roots_done;
            ST_SCAN: begin
                if (cand != '0) begin
                    cp_ctrl.re    = 1'b1;
                    cp_ctrl.raddr = low_col;
                end else if (!at_root) begin
                    rs_re   = 1'b1;
                    rs_addr = stack_row[depth_dn];
                end
            end
            ST_PROBE: begin
                if (cp_rvalid) begin
                    rs_re   = 1'b1;
                    rs_addr = cp_rdata;
                end else begin
                    cp_ctrl.we    = 1'b1;
                    cp_ctrl.waddr = col_reg;
                end
            end
            ST_UNWIND: begin
                cp_ctrl.we    = 1'b1;
                cp_ctrl.waddr = col_reg;
            end
            ST_DONE:  done = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                root_reg <= '0;
                size_reg <= '0;
            end
            ST_ROOT: begin
                depth_reg    <= '0;
                visited_reg  <= '0;
                top_row_reg  <= root_reg[RW-1:0];
                stack_row[0] <= root_reg[RW-1:0];
            end
            ST_FETCH: top_bits_reg <= rs_data;
            ST_SCAN: begin
                if (cand != '0) begin
                    col_reg              <= low_col;
                    visited_reg[low_col] <= 1'b1;
                end else if (at_root) begin
                    root_reg <= root_reg + CNTW'(1);
                end else begin
                    depth_reg   <= depth_dn;
                    top_row_reg <= stack_row[depth_dn];
                end
            end
            ST_PROBE: begin
                if (cp_rvalid) begin
                    // column taken: descend into its current partner row
                    stack_col[depth_reg]          <= col_reg;
                    stack_row[depth_reg + RW'(1)] <= cp_rdata;
                    depth_reg                     <= depth_reg + RW'(1);
                    top_row_reg                   <= cp_rdata;
                end else if (at_root) begin
                    root_reg <= root_reg + CNTW'(1);
                    size_reg <= size_reg + SIZE_W'(1);
                end else begin
                    col_reg     <= stack_col[depth_dn];
                    top_row_reg <= stack_row[depth_dn];
                    depth_reg   <= depth_dn;
                end
            end
            ST_UNWIND: begin
                // flip the path: each row on the stack takes the column that was probed from it
                if (at_root) begin
                    root_reg <= root_reg + CNTW'(1);
                    size_reg <= size_reg + SIZE_W'(1);
                end else begin
                    col_reg     <= stack_col[depth_dn];
                    top_row_reg <= stack_row[depth_dn];
                    depth_reg   <= depth_dn;
                end
            end
            default: ;
        endcase
    end

    assign size = size_reg;

    a_done_only_when_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (root_reg == rows))
        else $error("result issued before all roots searched");
    a_size_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ({1'b0, size_reg} <= (SIZE_W+1)'(root_reg)))
        else $error("matching larger than roots searched");
    a_write_only_free_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && !cp_rvalid) |-> visited_reg[col_reg])
        else $error("claimed column not marked visited");

endmodule

/* design/bipartite_perfect_matching.sv */
// Maximum bipartite matching over a square 0/1 matrix loaded one row per word.
// Each input word is one row; rows are written to a row memory until the word
// with s_tlast, then a sequencer runs one augmenting-path search per loaded row.
// Each column tried costs a partner-memory probe; descending into the column's
// partner row costs a row-memory read, returning from an exhausted row re-reads
// the parent row, and a successful search writes the partner memory once per
// column flipped. One search visits at most n-1 taken columns; no input is taken
// while the search runs. One result word follows each s_tlast word: the matching
// size and a flag set when it equals n.
module bipartite_perfect_matching
    import bpm_pkg::*;
#(
    parameter int MAX_SIZE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,    // matrix_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // row_bits
    input  logic        s_tlast,     // last_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // matching_size, then zero padding
    output logic        m_tuser      // is_perfect
);

    localparam int RW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CNTW = $clog2(MAX_SIZE + 1);
    localparam logic [N_W-1:0] MAX_N = N_W'(MAX_SIZE);

    logic [CFG_W-1:0]  size_cfg_reg;
    logic [CNTW-1:0]   row_count_reg, row_count_next;
    logic              busy_reg;
    logic              start_reg;
    logic [CNTW-1:0]   rows_reg;
    logic [ROW_W-1:0]  cmask_reg;
    logic              out_valid_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              out_perfect_reg;

    logic [N_W-1:0]    n_eff;
    logic              in_word;
    logic              store_row;
    logic [N_W-1:0]    rows_clamp;
    logic [ROW_W-1:0]  cmask_now;
    logic              out_free;
    logic              search_done;
    logic [SIZE_W-1:0] search_size;
    logic              rs_re;
    logic [RW-1:0]     rs_addr;
    logic [ROW_W-1:0]  rs_data;
    cp_ctrl_t          cp_ctrl;
    logic [RW-1:0]     cp_wdata;
    logic              cp_rvalid;
    logic [RW-1:0]     cp_rdata;

    always_comb begin
        priority if (size_cfg_reg == '0) begin
            n_eff = N_W'(1);
        end else if (N_W'(size_cfg_reg) > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = N_W'(size_cfg_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_word   = s_tvalid && s_tready;
    assign store_row = in_word && (N_W'(row_count_reg) < n_eff);

    assign row_count_next = store_row ? row_count_reg + CNTW'(1) : row_count_reg;
    assign rows_clamp = (N_W'(row_count_next) < n_eff) ? N_W'(row_count_next) : n_eff;
    assign cmask_now  = (n_eff >= N_W'(NUM_COLS)) ? '1
                      : ((ROW_W'(1) << n_eff[COL_W-1:0]) - ROW_W'(1));
    assign out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg  <= CFG_W'(32);
            row_count_reg <= '0;
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_cfg_reg <= cfg_data;
            end
            start_reg <= 1'b0;
            if (in_word && s_tlast) begin
                row_count_reg <= '0;
                busy_reg      <= 1'b1;
                start_reg     <= 1'b1;
            end else begin
                row_count_reg <= row_count_next;
            end
            if (search_done) begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_word && s_tlast) begin
            rows_reg  <= rows_clamp[CNTW-1:0];
            cmask_reg <= cmask_now;
        end
        if (search_done) begin
            out_size_reg    <= search_size;
            out_perfect_reg <= ({1'b0, search_size} == n_eff);
        end
    end

    bpm_row_store #(
        .DEPTH (MAX_SIZE),
        .AW    (RW)
    ) u_row_store (
        .aclk  (aclk),
        .we    (store_row),
        .waddr (row_count_reg[RW-1:0]),
        .wdata (s_tdata),
        .re    (rs_re),
        .raddr (rs_addr),
        .rdata (rs_data)
    );

    bpm_col_partner #(
        .RW (RW)
    ) u_col_partner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cp_ctrl),
        .wdata   (cp_wdata),
        .rvalid  (cp_rvalid),
        .rdata   (cp_rdata)
    );

    bpm_search #(
        .MAX_SIZE (MAX_SIZE),
        .RW       (RW),
        .CNTW     (CNTW)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .rows      (rows_reg),
        .cmask     (cmask_reg),
        .out_free  (out_free),
        .done      (search_done),
        .size      (search_size),
        .rs_re     (rs_re),
        .rs_addr   (rs_addr),
        .rs_data   (rs_data),
        .cp_ctrl   (cp_ctrl),
        .cp_wdata  (cp_wdata),
        .cp_rvalid (cp_rvalid),
        .cp_rdata  (cp_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_size_reg};
    assign m_tuser  = out_perfect_reg;

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        search_done |-> out_free)
        else $error("result overwritten before taken");
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        N_W'(row_count_reg) <= MAX_N)
        else $error("row count beyond memory depth");
    a_start_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_word && s_tlast) |=> (start_reg && busy_reg && row_count_reg == '0))
        else $error("search not launched after final row");

endmodule
